// ===== design/tsd_pkg.sv =====
package tsd_pkg;

    localparam int NODE_W = 6;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CYCLE    = 2'd1,
        ST_IN_EDGES = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_PATH = 2'd1,
        MARK_DONE = 2'd2,
        MARK_SPARE = 2'd3
    } mark_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] sort_index;
        logic [1:0]        status;
        logic              last;
    } result_t;

endpackage

// ===== design/topological_sort_dfs.sv =====
// Topological sort engine, depth-first, on a loaded edge table.
// Requests: drive req and raise start; a request is taken on a rising edge
// with start high and busy low. busy stays high while a request is worked.
//   add edge : stored in the edge table, no result; when the table is full a
//              single "table full" result follows on the next cycle.
//   clear    : empties the edge table, no result.
//   sort     : a clearing pass writes node_count visit marks (one a cycle),
//              then the walk: each root is tried, stack entries are popped
//              and every edge is scanned for each expanded node; the in-edge
//              check then scans all edges once per node. Results follow:
//              one record per node, highest finish index first, last set
//              on the final one. A cycle or an in-edge overflow gives a
//              single record instead.
// Each result sits on result for one cycle, marked by result_valid; the
// receiver cannot stall it. The user must write node_count (cfg_we/cfg_data)
// only while idle; the block does not enforce this. Reset empties the edge
// table, sets node_count to 64; visit marks are cleared at each sort start.
module topological_sort_dfs #(
    parameter int MAX_NODES    = 64,
    parameter int MAX_EDGES    = 256,
    parameter int MAX_IN_EDGES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tsd_pkg::req_t   req,
    output logic            busy,
    output logic            result_valid,
    output tsd_pkg::result_t result,
    input  logic            cfg_we,
    input  logic [6:0]      cfg_data
);
    import tsd_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int SD  = MAX_NODES + MAX_EDGES;
    localparam int SAW = $clog2(SD);
    localparam int SCW = $clog2(SD + 1);
    localparam int NAW = $clog2(MAX_NODES);
    localparam int FCW = $clog2(MAX_NODES + 1);
    localparam int CW  = $clog2(MAX_IN_EDGES + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_ROOT, S_ROOTW, S_POP, S_POPW, S_POPM,
        S_EDGE, S_EDGEW, S_EDGEM, S_CNT, S_CNTW, S_EMIT, S_EMITW
    } state_t;

    state_t           state_reg;
    logic [6:0]       node_count_reg;
    logic [ECW-1:0]   edge_total_reg;
    logic [ECW-1:0]   eidx_reg;
    logic [SCW-1:0]   top_reg;
    logic [FCW-1:0]   fin_total_reg;
    logic [FCW-1:0]   emit_cnt_reg;
    logic [6:0]       root_reg;
    logic [6:0]       v_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NODE_W-1:0] cur_reg;
    result_t          res_reg;
    logic             res_valid_reg;

    // memory ports
    logic                 e_we;
    logic [EAW-1:0]       e_addr_w, e_addr_r;
    logic [2*NODE_W-1:0]  e_wdata, e_rdata;
    logic                 s_we;
    logic [SAW-1:0]       s_addr_w, s_addr_r;
    logic [NODE_W-1:0]    s_wdata, s_rdata;
    logic                 f_we;
    logic [NAW-1:0]       f_addr_w, f_addr_r;
    logic [NODE_W-1:0]    f_rdata;
    logic                 m_we;
    logic [NAW-1:0]       m_addr_w, m_addr_r;
    logic [1:0]           m_wdata, m_rdata;

    logic [6:0]        n_eff;
    logic [NODE_W-1:0] e_src, e_dst;

    tsd_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(e_we), .waddr(e_addr_w), .wdata(e_wdata),
        .raddr(e_addr_r), .rdata(e_rdata)
    );
    tsd_ram #(.WIDTH(NODE_W), .DEPTH(SD)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_addr_w), .wdata(s_wdata),
        .raddr(s_addr_r), .rdata(s_rdata)
    );
    tsd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish (
        .clk(clk), .we(f_we), .waddr(f_addr_w), .wdata(cur_reg),
        .raddr(f_addr_r), .rdata(f_rdata)
    );
    tsd_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_marks (
        .clk(clk), .we(m_we), .waddr(m_addr_w), .wdata(m_wdata),
        .raddr(m_addr_r), .rdata(m_rdata)
    );

    assign e_src = e_rdata[2*NODE_W-1:NODE_W];
    assign e_dst = e_rdata[NODE_W-1:0];

    always_comb
    begin
        if (node_count_reg == 7'd0)
            n_eff = 7'd1;
        else if (node_count_reg > 7'(MAX_NODES))
            n_eff = 7'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    // memory control; a mark is addressed in the state before the one that uses it
    always_comb
    begin
        e_we     = 1'b0;
        e_addr_w = edge_total_reg[EAW-1:0];
        e_wdata  = {req.from_node, req.to_node};
        e_addr_r = eidx_reg[EAW-1:0];
        s_we     = 1'b0;
        s_addr_w = top_reg[SAW-1:0];
        s_wdata  = root_reg[NODE_W-1:0];
        s_addr_r = SAW'(top_reg - SCW'(1));
        f_we     = 1'b0;
        f_addr_w = fin_total_reg[NAW-1:0];
        f_addr_r = NAW'(emit_cnt_reg - FCW'(1));
        m_we     = 1'b0;
        m_addr_w = cur_reg[NAW-1:0];
        m_wdata  = MARK_FREE;
        m_addr_r = cur_reg[NAW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                e_we = start && (req.cmd == CMD_ADD) &&
                       (edge_total_reg < ECW'(MAX_EDGES));
            end
            S_CLR:
            begin
                m_we     = 1'b1;
                m_addr_w = v_reg[NAW-1:0];
            end
            S_ROOT:
            begin
                m_addr_r = root_reg[NAW-1:0];
            end
            S_ROOTW:
            begin
                s_addr_w = '0;
                s_we = (m_rdata == MARK_FREE);
            end
            S_POPW:
            begin
                m_addr_r = s_rdata[NAW-1:0];
            end
            S_POPM:
            begin
                s_wdata = cur_reg;
                if (m_rdata == MARK_PATH)
                begin
                    m_we    = 1'b1;
                    m_wdata = MARK_DONE;
                    f_we    = (fin_total_reg < FCW'(MAX_NODES));
                end
                else if (m_rdata == MARK_FREE)
                begin
                    m_we    = 1'b1;
                    m_wdata = MARK_PATH;
                    s_we    = (top_reg < SCW'(SD));
                end
            end
            S_EDGEW:
            begin
                m_addr_r = e_dst[NAW-1:0];
            end
            S_EDGEM:
            begin
                s_wdata = e_dst;
                s_we = (m_rdata == MARK_FREE) && (top_reg < SCW'(SD));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 7'd64;
            edge_total_reg <= '0;
            eidx_reg       <= '0;
            top_reg        <= '0;
            fin_total_reg  <= '0;
            emit_cnt_reg   <= '0;
            root_reg       <= '0;
            v_reg          <= '0;
            cnt_reg        <= '0;
            cur_reg        <= '0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (req.cmd)
                            CMD_ADD:
                            begin
                                if (edge_total_reg < ECW'(MAX_EDGES))
                                    edge_total_reg <= edge_total_reg + ECW'(1);
                                else
                                begin
                                    res_reg       <= '{'0, '0, ST_FULL, 1'b1};
                                    res_valid_reg <= 1'b1;
                                end
                            end
                            CMD_SORT:
                            begin
                                fin_total_reg <= '0;
                                v_reg         <= '0;
                                state_reg     <= S_CLR;
                            end
                            CMD_CLEAR: edge_total_reg <= '0;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    if (v_reg + 7'd1 >= n_eff)
                    begin
                        root_reg  <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                        v_reg <= v_reg + 7'd1;
                end
                S_ROOT:
                begin
                    if (root_reg >= n_eff)
                    begin
                        v_reg     <= '0;
                        eidx_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_CNT;
                    end
                    else
                        state_reg <= S_ROOTW;
                end
                S_ROOTW:
                begin
                    if (m_rdata != MARK_FREE)
                    begin
                        root_reg  <= root_reg + 7'd1;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        top_reg   <= SCW'(1);
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (top_reg == '0)
                    begin
                        root_reg  <= root_reg + 7'd1;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        top_reg   <= top_reg - SCW'(1);
                        state_reg <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    cur_reg <= s_rdata;
                    if ({1'b0, s_rdata} < n_eff)
                        state_reg <= S_POPM;
                    else
                        state_reg <= S_POP;
                end
                S_POPM:
                begin
                    state_reg <= S_POP;
                    if (m_rdata == MARK_PATH)
                    begin
                        if (fin_total_reg < FCW'(MAX_NODES))
                            fin_total_reg <= fin_total_reg + FCW'(1);
                    end
                    else if (m_rdata == MARK_FREE)
                    begin
                        if (top_reg < SCW'(SD))
                            top_reg <= top_reg + SCW'(1);
                        eidx_reg  <= '0;
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    if (eidx_reg >= edge_total_reg)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_EDGEW;
                end
                S_EDGEW:
                begin
                    // edge address is held, so the edge stays on e_rdata
                    if ((e_src == cur_reg) && ({1'b0, e_dst} < n_eff))
                        state_reg <= S_EDGEM;
                    else
                    begin
                        eidx_reg  <= eidx_reg + ECW'(1);
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGEM:
                begin
                    eidx_reg  <= eidx_reg + ECW'(1);
                    state_reg <= S_EDGE;
                    if (m_rdata == MARK_FREE)
                    begin
                        if (top_reg < SCW'(SD))
                            top_reg <= top_reg + SCW'(1);
                    end
                    else if (m_rdata == MARK_PATH)
                    begin
                        res_reg       <= '{e_dst, '0, ST_CYCLE, 1'b1};
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_CNT:
                begin
                    if (eidx_reg >= edge_total_reg)
                    begin
                        if (cnt_reg > CW'(MAX_IN_EDGES))
                        begin
                            res_reg <= '{v_reg[NODE_W-1:0], '0, ST_IN_EDGES, 1'b1};
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else if (v_reg + 7'd1 >= n_eff)
                        begin
                            emit_cnt_reg <= fin_total_reg;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            v_reg    <= v_reg + 7'd1;
                            eidx_reg <= '0;
                            cnt_reg  <= '0;
                        end
                    end
                    else
                        state_reg <= S_CNTW;
                end
                S_CNTW:
                begin
                    // saturates just above the limit
                    if ({1'b0, e_dst} == v_reg && {1'b0, e_src} < n_eff &&
                        cnt_reg <= CW'(MAX_IN_EDGES))
                        cnt_reg <= cnt_reg + CW'(1);
                    eidx_reg  <= eidx_reg + ECW'(1);
                    state_reg <= S_CNT;
                end
                S_EMIT:
                begin
                    if (emit_cnt_reg == '0)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_EMITW;
                end
                S_EMITW:
                begin
                    res_reg <= '{f_rdata, NODE_W'(emit_cnt_reg - FCW'(1)), ST_OK,
                                 emit_cnt_reg == FCW'(1)};
                    res_valid_reg <= 1'b1;
                    emit_cnt_reg  <= emit_cnt_reg - FCW'(1);
                    state_reg     <= (emit_cnt_reg == FCW'(1)) ? S_IDLE : S_EMIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== design/tsd_ram.sv =====
module tsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
